// File: hdl/smma_pkg.sv
// ----------------------------------------------------------------------------
// smma_pkg
// Shared types and constants of the scaled matrix multiply-accumulate core.
// ----------------------------------------------------------------------------
package smma_pkg;

	localparam int MAX_ROWS  = 8;
	localparam int MAX_INNER = 8;
	localparam int MAX_COLS  = 8;

	localparam int IDX_W  = 3;
	localparam int ELEM_W = 16;
	localparam int PROD_W = 32;
	localparam int SUM_W  = 36;

	localparam logic [1:0] CMD_WRITE_A = 2'd0;
	localparam logic [1:0] CMD_WRITE_B = 2'd1;
	localparam logic [1:0] CMD_WRITE_C = 2'd2;
	localparam logic [1:0] CMD_COMPUTE = 2'd3;

	localparam logic [2:0] REG_ALPHA = 3'd0;
	localparam logic [2:0] REG_BETA  = 3'd1;
	localparam logic [2:0] REG_ROWS  = 3'd2;
	localparam logic [2:0] REG_INNER = 3'd3;
	localparam logic [2:0] REG_COLS  = 3'd4;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOAD,
		ST_RUN,
		ST_SCALE
	} state_t;

endpackage

// File: hdl/scaled_matrix_multiply_accumulate_core.sv
// ----------------------------------------------------------------------------
// scaled_matrix_multiply_accumulate_core
// C := alpha*(A x B) + beta*C in signed Q8.8, built on a chain of MAC cells.
//
// Input channel: command/row/col/value with in_valid/in_stall. Write commands
// store one element each and are taken one per cycle while idle. A compute
// command walks rows_used x cols_used elements; for each, a chain of MAX_INNER
// cells forms the dot product, one cell per cycle, and the scaler adds the
// beta term. Elements go one at a time, paced by the walk along the chain and
// the single element-store read port; in_stall stays high for the whole run.
// Output channel: out_row/out_col/result/last with out_valid/out_stall, held
// in an output register; the run waits while it is full and out_stall is high.
// Configuration: APB writes at byte address 4*index; the user must write only
// while idle, which the block does not enforce. Reset clears control and
// registers to their defaults; stores are undefined until written.
// ----------------------------------------------------------------------------
module scaled_matrix_multiply_accumulate_core #(
	parameter int MAX_ROWS  = smma_pkg::MAX_ROWS,
	parameter int MAX_INNER = smma_pkg::MAX_INNER,
	parameter int MAX_COLS  = smma_pkg::MAX_COLS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  command,
	input  logic [2:0]  row,
	input  logic [2:0]  col,
	input  logic signed [15:0] value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  out_row,
	output logic [2:0]  out_col,
	output logic signed [15:0] result,
	output logic        last
);

	localparam int EW = smma_pkg::ELEM_W;
	localparam int SW = smma_pkg::SUM_W;

	logic signed [EW-1:0] alpha_q, beta_q;
	logic [3:0] rows_q, inner_q, cols_q;
	logic [3:0] nr, nk, nc;

	assign pready = 1'b1;
	always_comb begin
		unique case (paddr[4:2])
			smma_pkg::REG_ALPHA: prdata = {16'd0, alpha_q};
			smma_pkg::REG_BETA:  prdata = {16'd0, beta_q};
			smma_pkg::REG_ROWS:  prdata = {28'd0, rows_q};
			smma_pkg::REG_INNER: prdata = {28'd0, inner_q};
			smma_pkg::REG_COLS:  prdata = {28'd0, cols_q};
			default:             prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= 16'sd256;
			beta_q  <= '0;
			rows_q  <= 4'd8;
			inner_q <= 4'd8;
			cols_q  <= 4'd8;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[4:2])
				smma_pkg::REG_ALPHA: alpha_q <= pwdata[15:0];
				smma_pkg::REG_BETA:  beta_q  <= pwdata[15:0];
				smma_pkg::REG_ROWS:  rows_q  <= pwdata[3:0];
				smma_pkg::REG_INNER: inner_q <= pwdata[3:0];
				smma_pkg::REG_COLS:  cols_q  <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	assign nr = (rows_q  > 4'(MAX_ROWS))  ? 4'(MAX_ROWS)  : rows_q;
	assign nk = (inner_q > 4'(MAX_INNER)) ? 4'(MAX_INNER) : inner_q;
	assign nc = (cols_q  > 4'(MAX_COLS))  ? 4'(MAX_COLS)  : cols_q;

	// Stores: flat 8x8 addressing, {row, col}
	logic [EW-1:0] a_mem [64];
	logic [EW-1:0] b_mem [64];
	logic [EW-1:0] c_mem [64];

	smma_pkg::state_t state_q, state_d;
	logic [2:0] i_q, j_q;
	logic [3:0] k_q;
	logic [1:0] sc_q;
	logic       obuf_full_q;
	logic       accept;
	logic [5:0] a_addr, b_addr, c_addr;
	logic [EW-1:0] a_rd_q, b_rd_q, c_rd_q;
	logic signed [SW-1:0] chain [MAX_INNER+1];
	logic signed [EW-1:0] res;
	logic [3:0] step_q;
	logic       cell_en_q;
	logic       use_q;
	logic       wr_back;
	logic       elem_last;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != smma_pkg::ST_IDLE);

	// writes
	always_ff @(posedge clk) begin
		if (accept && command == smma_pkg::CMD_WRITE_A && {1'b0, row} < 4'(MAX_ROWS)
			&& {1'b0, col} < 4'(MAX_INNER))
			a_mem[{row, col}] <= value;
		if (accept && command == smma_pkg::CMD_WRITE_B && {1'b0, row} < 4'(MAX_INNER)
			&& {1'b0, col} < 4'(MAX_COLS))
			b_mem[{row, col}] <= value;
		if (accept && command == smma_pkg::CMD_WRITE_C && {1'b0, row} < 4'(MAX_ROWS)
			&& {1'b0, col} < 4'(MAX_COLS))
			c_mem[{row, col}] <= value;
		else if (wr_back)
			c_mem[{i_q, j_q}] <= res;
	end

	assign a_addr = {i_q, k_q[2:0]};
	assign b_addr = {k_q[2:0], j_q};
	assign c_addr = {i_q, j_q};
	always_ff @(posedge clk) begin
		a_rd_q <= a_mem[a_addr];
		b_rd_q <= b_mem[b_addr];
		c_rd_q <= c_mem[c_addr];
	end

	// chain: one cell enabled per cycle, stepping along the row
	assign chain[0] = '0;
	genvar g;
	generate
		for (g = 0; g < MAX_INNER; g++) begin : g_cell
			smma_mac_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.en       (cell_en_q && step_q == 4'(g)),
				.a        (a_rd_q),
				.b        (b_rd_q),
				.use_term (use_q),
				.sum_in   (chain[g]),
				.sum_out  (chain[g+1])
			);
		end
	endgenerate

	smma_scale u_scale (
		.clk    (clk),
		.sum    (chain[MAX_INNER]),
		.alpha  (alpha_q),
		.beta   (beta_q),
		.c_old  (c_rd_q),
		.phase  (sc_q != 2'd0),
		.result (res)
	);

	assign elem_last = ({1'b0, i_q} == nr - 4'd1) && ({1'b0, j_q} == nc - 4'd1);
	assign wr_back   = (state_q == smma_pkg::ST_SCALE) && (sc_q == 2'd1) && !obuf_full_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			smma_pkg::ST_IDLE:
				if (accept && command == smma_pkg::CMD_COMPUTE)
					state_d = (nr == 4'd0 || nc == 4'd0) ? smma_pkg::ST_IDLE
					                                     : smma_pkg::ST_LOAD;
			smma_pkg::ST_LOAD:  state_d = smma_pkg::ST_RUN;
			smma_pkg::ST_RUN:
				if (step_q == 4'(MAX_INNER - 1) && cell_en_q)
					state_d = smma_pkg::ST_SCALE;
			smma_pkg::ST_SCALE:
				if (wr_back)
					state_d = elem_last ? smma_pkg::ST_IDLE : smma_pkg::ST_LOAD;
			default: state_d = smma_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= smma_pkg::ST_IDLE;
			i_q         <= '0;
			j_q         <= '0;
			k_q         <= '0;
			step_q      <= '0;
			cell_en_q   <= 1'b0;
			use_q       <= 1'b0;
			sc_q        <= '0;
			obuf_full_q <= 1'b0;
			out_row     <= '0;
			out_col     <= '0;
			result      <= '0;
			last        <= 1'b0;
		end else begin
			state_q <= state_d;
			if (obuf_full_q && !out_stall)
				obuf_full_q <= 1'b0;
			unique case (state_q)
				smma_pkg::ST_IDLE: begin
					i_q <= '0;
					j_q <= '0;
					k_q <= '0;
				end
				smma_pkg::ST_LOAD: begin
					// read of term 0 issued; advance address
					k_q       <= k_q + 4'd1;
					step_q    <= '0;
					cell_en_q <= 1'b1;
					use_q     <= nk != 4'd0;
				end
				smma_pkg::ST_RUN: begin
					if (k_q < 4'(MAX_INNER))
						k_q <= k_q + 4'd1;
					step_q <= step_q + 4'd1;
					use_q  <= (step_q + 4'd1) < nk;
					if (step_q == 4'(MAX_INNER - 1)) begin
						cell_en_q <= 1'b0;
						sc_q      <= '0;
					end
				end
				smma_pkg::ST_SCALE: begin
					if (sc_q == 2'd0)
						sc_q <= 2'd1;
					if (wr_back) begin
						obuf_full_q <= 1'b1;
						out_row     <= i_q;
						out_col     <= j_q;
						result      <= res;
						last        <= elem_last;
						k_q         <= '0;
						if ({1'b0, j_q} == nc - 4'd1) begin
							j_q <= '0;
							i_q <= i_q + 3'd1;
						end else begin
							j_q <= j_q + 3'd1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	assign out_valid = obuf_full_q;

endmodule

// File: hdl/smma_mac_cell.sv
// ----------------------------------------------------------------------------
// smma_mac_cell
// One cell of the dot-product chain: multiplies its a and b element and adds
// the previous cell's partial sum when use_term is set, passing the sum on.
// ----------------------------------------------------------------------------
module smma_mac_cell (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic signed [smma_pkg::ELEM_W-1:0]  a,
	input  logic signed [smma_pkg::ELEM_W-1:0]  b,
	input  logic                                use_term,
	input  logic signed [smma_pkg::SUM_W-1:0]   sum_in,
	output logic signed [smma_pkg::SUM_W-1:0]   sum_out
);

	logic signed [smma_pkg::PROD_W-1:0] prod;

	assign prod = a * b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_out <= '0;
		end else if (en) begin
			sum_out <= use_term ? sum_in + smma_pkg::SUM_W'(prod) : sum_in;
		end
	end

endmodule

// File: hdl/smma_scale.sv
// ----------------------------------------------------------------------------
// smma_scale
// Output scaling: alpha*sum + beta*C*256, floor shift by 16, Q8.8 saturation.
// The products are registered while phase is low; the sum is combinational.
// ----------------------------------------------------------------------------
module smma_scale (
	input  logic                                clk,
	input  logic signed [smma_pkg::SUM_W-1:0]   sum,
	input  logic signed [smma_pkg::ELEM_W-1:0]  alpha,
	input  logic signed [smma_pkg::ELEM_W-1:0]  beta,
	input  logic signed [smma_pkg::ELEM_W-1:0]  c_old,
	input  logic                                phase,
	output logic signed [smma_pkg::ELEM_W-1:0]  result
);

	// sum split into low 18 bits (unsigned) and high 18 bits (signed)
	logic signed [35:0] lo_prod_s1;
	logic signed [35:0] hi_prod_s1;
	logic signed [31:0] bc_s1;
	logic signed [59:0] total;
	logic signed [43:0] shifted;

	always_ff @(posedge clk) begin
		if (!phase) begin
			lo_prod_s1 <= alpha * $signed({1'b0, sum[17:0]});
			hi_prod_s1 <= alpha * $signed(sum[35:18]);
			bc_s1      <= beta * c_old;
		end
	end

	always_comb begin
		total = (60'(hi_prod_s1) <<< 18) + 60'(lo_prod_s1) + (60'(bc_s1) <<< 8);
		shifted = total[59:16];
		if (shifted > 44'sd32767)
			result = 16'sh7fff;
		else if (shifted < -44'sd32768)
			result = 16'sh8000;
		else
			result = shifted[15:0];
	end

endmodule
